>>> sv/csrm_pkg.sv
`default_nettype none

package csrm_pkg;

    // Bus access commands carried in the low bits of the input item.
    localparam logic [2:0] CMD_READ_BYTE  = 3'd0;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd1;
    localparam logic [2:0] CMD_READ_WORD  = 3'd2;
    localparam logic [2:0] CMD_WRITE_WORD = 3'd3;
    localparam logic [2:0] CMD_CONTROL    = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_WINDOW_BASE     = 3'd0;
    localparam logic [2:0] REG_WINDOW_SPAN     = 3'd1;
    localparam logic [2:0] REG_LANE_PACKED     = 3'd2;
    localparam logic [2:0] REG_ODD_LANE        = 3'd3;
    localparam logic [2:0] REG_BANK_SWITCHABLE = 3'd4;

    localparam int BUS_ADDR_W  = 24;
    localparam int BASE_W      = 22;
    localparam int SPAN_W      = 17;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_INDEX_W = 3;

    localparam logic [SPAN_W-1:0] SPAN_MAX      = 17'h10000;
    localparam logic [BASE_W-1:0] BASE_RESET    = 22'h200000;
    localparam logic [7:0]        FILL_BYTE     = 8'hFF;
    localparam logic [7:0]        CTRL_LOW_BYTE = 8'hF1;

    localparam int STORE_BYTES_DEF = 65536;

    // Result of resolving one bus byte address against the save window.
    typedef struct packed {
        logic hit;
        logic bank;
    } loc_t;

    // Per-cycle request to the two byte banks of the save store.
    typedef struct packed {
        logic rd_en;
        logic wr_en0;
        logic wr_en1;
    } store_ctl_t;

endpackage

`default_nettype wire

>>> sv/csrm_locate.sv
`default_nettype none

module csrm_locate #(
    parameter int ADDR_W = 16
) (
    input  wire logic [csrm_pkg::BUS_ADDR_W-1:0] addr,
    input  wire logic [csrm_pkg::BASE_W-1:0]     window_base,
    input  wire logic [csrm_pkg::SPAN_W-1:0]     window_span,
    input  wire logic                            lane_packed,
    input  wire logic                            odd_lane,
    input  wire logic                            live,
    output csrm_pkg::loc_t                       loc,
    output logic [ADDR_W-2:0]                    row
);
    import csrm_pkg::*;

    logic [BUS_ADDR_W:0]   diff;
    logic [BUS_ADDR_W-1:0] off;
    logic [SPAN_W-1:0]     span_eff;
    logic [BUS_ADDR_W-1:0] idx_full;
    logic [ADDR_W-1:0]     idx;
    logic                  in_range;
    logic                  lane_ok;

    // Base is forced even; a borrow out of the subtract means below the window.
    assign diff     = {1'b0, addr}
                    - {1'b0, {(BUS_ADDR_W-BASE_W){1'b0}}, window_base[BASE_W-1:1], 1'b0};
    assign off      = diff[BUS_ADDR_W-1:0];
    assign span_eff = window_span[SPAN_W-1] ? SPAN_MAX : window_span;
    assign in_range = !diff[BUS_ADDR_W]
                    && (off < {{(BUS_ADDR_W-SPAN_W){1'b0}}, span_eff});
    assign lane_ok  = !lane_packed || (off[0] == odd_lane);
    assign idx_full = lane_packed ? {1'b0, off[BUS_ADDR_W-1:1]} : off;
    assign idx      = idx_full[ADDR_W-1:0];

    assign loc.hit  = live && in_range && lane_ok;
    assign loc.bank = idx[0];
    assign row      = idx[ADDR_W-1:1];

endmodule

`default_nettype wire

>>> sv/csrm_store.sv
`default_nettype none

module csrm_store #(
    parameter int ROW_W = 15
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire csrm_pkg::store_ctl_t ctl,
    input  wire logic [ROW_W-1:0]     row0,
    input  wire logic [ROW_W-1:0]     row1,
    input  wire logic [7:0]           wdata0,
    input  wire logic [7:0]           wdata1,
    output logic [7:0]                rdata0,
    output logic [7:0]                rdata1,
    output logic                      clear_busy
);
    import csrm_pkg::*;

    localparam int DEPTH = 1 << ROW_W;

    // Even and odd byte banks, each one write and one read per cycle.
    logic [7:0] bank0_mem [DEPTH];
    logic [7:0] bank1_mem [DEPTH];

    logic             clr_busy_reg, clr_busy_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic [ROW_W-1:0] addr0, addr1;
    logic [7:0]       wd0, wd1;
    logic             we0, we1;
    logic [7:0]       rdata0_reg, rdata1_reg;

    // After reset every row is swept to the erased value once.
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_row_next  = clr_row_reg;
        if (clr_busy_reg) begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == {ROW_W{1'b1}}) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    assign addr0 = clr_busy_reg ? clr_row_reg : row0;
    assign addr1 = clr_busy_reg ? clr_row_reg : row1;
    assign wd0   = clr_busy_reg ? FILL_BYTE : wdata0;
    assign wd1   = clr_busy_reg ? FILL_BYTE : wdata1;
    assign we0   = clr_busy_reg || ctl.wr_en0;
    assign we1   = clr_busy_reg || ctl.wr_en1;

    always_ff @(posedge aclk) begin
        if (we0) begin
            bank0_mem[addr0] <= wd0;
        end
        if (ctl.rd_en && !clr_busy_reg) begin
            rdata0_reg <= bank0_mem[addr0];
        end
    end

    always_ff @(posedge aclk) begin
        if (we1) begin
            bank1_mem[addr1] <= wd1;
        end
        if (ctl.rd_en && !clr_busy_reg) begin
            rdata1_reg <= bank1_mem[addr1];
        end
    end

    assign rdata0     = rdata0_reg;
    assign rdata1     = rdata1_reg;
    assign clear_busy = clr_busy_reg;

endmodule

`default_nettype wire

>>> sv/cart_save_ram_bus_mapper.sv
`default_nettype none

// Cartridge save RAM mapper for a 68000 bus. Each input item is one bus access
// (byte or word read, byte or word write, or a write to the save RAM control
// register) and yields exactly one result item carrying the read data and the
// dirty, live and protect flags as they stand after that access. The block
// takes one item per clock unless a refused result holds the pipe, and
// presents its result on m_tvalid through three register stages: an input
// register, the store's registered read that also holds the resolved window
// lookup, and a result register. Word accesses take no longer than byte
// accesses because the store is split into an even and an odd byte bank,
// each with its own port. STORE_BYTES must be a power of two. After reset the
// block sweeps both banks to 0xFF, one row per cycle; s_tready stays low
// during that sweep while configuration writes are still taken.
// Configuration should only be written while no item is in flight.
module cart_save_ram_bus_mapper #(
    parameter int STORE_BYTES = csrm_pkg::STORE_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] cmd, [26:3] bus_address, [42:27] write_data, [47:43] zero
    input  wire logic [47:0] s_tdata,

    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] read_data, [16] save_dirty, [17] window_live,
    // [18] write_protected, [23:19] zero
    output logic [23:0]      m_tdata,

    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [21:0] cfg_data
);
    import csrm_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int ROW_W  = ADDR_W - 1;

    // Configuration registers.
    logic [BASE_W-1:0] base_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              packed_reg;
    logic              odd_reg;
    logic              bankable_reg;

    // Mapper flags.
    logic protect_reg, protect_next;
    logic live_reg, live_next;
    logic dirty_reg, dirty_next;

    // Input register stage.
    logic                  a_valid_reg;
    logic [2:0]            a_cmd_reg;
    logic [BUS_ADDR_W-1:0] a_addr_reg;
    logic [15:0]           a_data_reg;

    // Store access stage results, waiting for the registered read data.
    logic b_valid_reg;
    logic b_read_reg;
    logic b_word_reg;
    loc_t b_hi_reg;
    loc_t b_lo_reg;
    logic b_dirty_reg, b_live_reg, b_protect_reg;

    // Result register.
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic                  adv;
    logic                  clear_busy;
    logic                  cfg_fire;
    logic                  a_fire;
    logic                  is_read, is_write, is_word, is_ctrl;
    logic [BUS_ADDR_W-1:0] hi_addr, lo_addr;
    loc_t                  hi_loc, lo_loc;
    logic [ROW_W-1:0]      hi_row, lo_row;
    logic                  hi_use, lo_use;
    logic                  hi_b0, hi_b1, lo_b0, lo_b1;
    store_ctl_t            st_ctl;
    logic [ROW_W-1:0]      row0, row1;
    logic [7:0]            wdata0, wdata1;
    logic [7:0]            rdata0, rdata1;
    logic [7:0]            hi_byte, lo_byte;
    logic [15:0]           rd_value;

    // The whole pipe moves together; it only holds when a result is refused.
    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv && !clear_busy;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign a_fire    = adv && a_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= BASE_RESET;
            span_reg     <= '0;
            packed_reg   <= 1'b0;
            odd_reg      <= 1'b0;
            bankable_reg <= 1'b0;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_WINDOW_BASE:     base_reg     <= cfg_data[BASE_W-1:0];
                REG_WINDOW_SPAN:     span_reg     <= cfg_data[SPAN_W-1:0];
                REG_LANE_PACKED:     packed_reg   <= cfg_data[0];
                REG_ODD_LANE:        odd_reg      <= cfg_data[0];
                REG_BANK_SWITCHABLE: bankable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        is_read  = 1'b0;
        is_write = 1'b0;
        is_word  = 1'b0;
        is_ctrl  = 1'b0;
        unique case (a_cmd_reg)
            CMD_READ_BYTE:  is_read = 1'b1;
            CMD_WRITE_BYTE: is_write = 1'b1;
            CMD_READ_WORD: begin
                is_read = 1'b1;
                is_word = 1'b1;
            end
            CMD_WRITE_WORD: begin
                is_write = 1'b1;
                is_word  = 1'b1;
            end
            CMD_CONTROL:    is_ctrl = 1'b1;
            default: ;
        endcase
    end

    // The high byte of a word sits at the even address. Byte accesses use
    // only the low slot, at the address as given.
    assign hi_addr = {a_addr_reg[BUS_ADDR_W-1:1], 1'b0};
    assign lo_addr = is_word ? {a_addr_reg[BUS_ADDR_W-1:1], 1'b1} : a_addr_reg;

    csrm_locate #(
        .ADDR_W(ADDR_W)
    ) u_locate_hi (
        .addr        (hi_addr),
        .window_base (base_reg),
        .window_span (span_reg),
        .lane_packed (packed_reg),
        .odd_lane    (odd_reg),
        .live        (live_reg),
        .loc         (hi_loc),
        .row         (hi_row)
    );

    csrm_locate #(
        .ADDR_W(ADDR_W)
    ) u_locate_lo (
        .addr        (lo_addr),
        .window_base (base_reg),
        .window_span (span_reg),
        .lane_packed (packed_reg),
        .odd_lane    (odd_reg),
        .live        (live_reg),
        .loc         (lo_loc),
        .row         (lo_row)
    );

    // In word-wide mode the two bytes of a word land in different banks at
    // the same row; in packed mode at most one of them is backed at all, so
    // the two slots never compete for one bank.
    assign hi_use = is_word && hi_loc.hit;
    assign lo_use = lo_loc.hit;
    assign hi_b0  = hi_use && !hi_loc.bank;
    assign hi_b1  = hi_use && hi_loc.bank;
    assign lo_b0  = lo_use && !lo_loc.bank;
    assign lo_b1  = lo_use && lo_loc.bank;

    assign row0   = hi_b0 ? hi_row : lo_row;
    assign row1   = hi_b1 ? hi_row : lo_row;
    assign wdata0 = hi_b0 ? a_data_reg[15:8] : a_data_reg[7:0];
    assign wdata1 = hi_b1 ? a_data_reg[15:8] : a_data_reg[7:0];

    assign st_ctl.rd_en  = a_fire && is_read;
    assign st_ctl.wr_en0 = a_fire && is_write && !protect_reg && (hi_b0 || lo_b0);
    assign st_ctl.wr_en1 = a_fire && is_write && !protect_reg && (hi_b1 || lo_b1);

    csrm_store #(
        .ROW_W(ROW_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (st_ctl),
        .row0       (row0),
        .row1       (row1),
        .wdata0     (wdata0),
        .wdata1     (wdata1),
        .rdata0     (rdata0),
        .rdata1     (rdata1),
        .clear_busy (clear_busy)
    );

    // Rewriting the span or the bankable bit re-arms the flags. The control
    // register only answers at low byte F1 on a bankable cart with a window.
    always_comb begin
        protect_next = protect_reg;
        live_next    = live_reg;
        dirty_next   = dirty_reg || st_ctl.wr_en0 || st_ctl.wr_en1;
        if (cfg_fire && cfg_index == REG_WINDOW_SPAN) begin
            protect_next = 1'b0;
            live_next    = !bankable_reg && (cfg_data[SPAN_W-1:0] != '0);
        end else if (cfg_fire && cfg_index == REG_BANK_SWITCHABLE) begin
            protect_next = 1'b0;
            live_next    = !cfg_data[0] && (span_reg != '0);
        end else if (a_fire && is_ctrl && a_addr_reg[7:0] == CTRL_LOW_BYTE
                     && span_reg != '0 && bankable_reg) begin
            protect_next = a_data_reg[1];
            live_next    = a_data_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protect_reg <= 1'b0;
            live_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
        end else begin
            protect_reg <= protect_next;
            live_reg    <= live_next;
            dirty_reg   <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg  <= s_tvalid && s_tready;
            b_valid_reg  <= a_valid_reg;
            m_tvalid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_cmd_reg     <= s_tdata[2:0];
            a_addr_reg    <= s_tdata[26:3];
            a_data_reg    <= s_tdata[42:27];
            b_read_reg    <= is_read;
            b_word_reg    <= is_word;
            b_hi_reg      <= hi_loc;
            b_lo_reg      <= lo_loc;
            b_dirty_reg   <= dirty_next;
            b_live_reg    <= live_next;
            b_protect_reg <= protect_next;
            m_tdata_reg   <= {5'b0, b_protect_reg, b_live_reg, b_dirty_reg, rd_value};
        end
    end

    // Bytes that are not backed read as the erased value.
    assign hi_byte = b_hi_reg.hit ? (b_hi_reg.bank ? rdata1 : rdata0) : FILL_BYTE;
    assign lo_byte = b_lo_reg.hit ? (b_lo_reg.bank ? rdata1 : rdata0) : FILL_BYTE;

    always_comb begin
        priority if (!b_read_reg) begin
            rd_value = '0;
        end else if (b_word_reg) begin
            rd_value = {hi_byte, lo_byte};
        end else begin
            rd_value = {8'h00, lo_byte};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // No item may enter while the store is still being erased.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready && !a_valid_reg && !b_valid_reg)
        else $error("item in flight during store erase");

    // Store writes come only from an advancing, unprotected write item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_ctl.wr_en0 || st_ctl.wr_en1) |-> a_fire && is_write && !protect_reg)
        else $error("store written outside an unprotected write");

    // The dirty flag only drops through reset.
    assert property (@(posedge aclk)
        $fell(dirty_reg) |-> !$past(aresetn))
        else $error("dirty flag cleared without reset");

    // A held result keeps its flags and data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
import csrm_pkg::*;

// One result item as it sits in m_tdata[18:0].
typedef struct packed {
    logic        write_protected;
    logic        window_live;
    logic        save_dirty;
    logic [15:0] read_data;
} bus_result_t;

// Tracks the save RAM contents and flags, and checks each result in order.
class save_ram_checker;
    logic [BASE_W-1:0] base_cfg;
    logic [SPAN_W-1:0] span_cfg;
    bit                lane_packed_cfg;
    bit                odd_lane_cfg;
    bit                bank_cfg;
    bit                protect_on;
    bit                live_on;
    bit                dirty_on;
    logic [7:0]        ram_image [STORE_BYTES_DEF];
    bus_result_t       expected_bus_results [$];
    int unsigned       mismatches;

    function new();
        base_cfg = BASE_RESET;
        span_cfg = '0;
        lane_packed_cfg = 1'b0;
        odd_lane_cfg = 1'b0;
        bank_cfg = 1'b0;
        dirty_on = 1'b0;
        mismatches = 0;
        foreach (ram_image[i]) ram_image[i] = FILL_BYTE;
        rearm();
    endfunction

    function void rearm();
        protect_on = 1'b0;
        live_on = !bank_cfg && span_cfg != 0;
    endfunction

    // Maps a bus byte address to a store index; returns 0 when nothing backs it.
    function bit locate(int unsigned addr, output int unsigned idx);
        int unsigned base_even;
        int unsigned off;
        int unsigned reach;
        base_even = {10'd0, base_cfg[BASE_W-1:1], 1'b0};
        reach = (span_cfg > SPAN_MAX) ? SPAN_MAX : span_cfg;
        idx = 0;
        if (!live_on || addr < base_even) return 1'b0;
        off = addr - base_even;
        if (off >= reach) return 1'b0;
        if (lane_packed_cfg) begin
            if (off[0] != odd_lane_cfg) return 1'b0;
            off = off >> 1;
        end
        idx = off % STORE_BYTES_DEF;
        return 1'b1;
    endfunction

    function logic [7:0] fetch_byte(int unsigned addr);
        int unsigned idx;
        if (!locate(addr, idx)) return FILL_BYTE;
        return ram_image[idx];
    endfunction

    function void store_byte(int unsigned addr, logic [7:0] value);
        int unsigned idx;
        if (protect_on) return;
        if (!locate(addr, idx)) return;
        ram_image[idx] = value;
        dirty_on = 1'b1;
    endfunction

    function void apply_register(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_WINDOW_BASE: base_cfg = value[BASE_W-1:0];
            REG_WINDOW_SPAN: begin
                span_cfg = value[SPAN_W-1:0];
                rearm();
            end
            REG_LANE_PACKED: lane_packed_cfg = value[0];
            REG_ODD_LANE: odd_lane_cfg = value[0];
            REG_BANK_SWITCHABLE: begin
                bank_cfg = value[0];
                rearm();
            end
            default: ;
        endcase
    endfunction

    function void note_access(logic [2:0] cmd, logic [23:0] addr, logic [15:0] data);
        int unsigned even_addr;
        bus_result_t want;
        even_addr = {8'd0, addr[23:1], 1'b0};
        want = '0;
        case (cmd)
            CMD_READ_BYTE: want.read_data = {8'h00, fetch_byte(addr)};
            CMD_WRITE_BYTE: store_byte(addr, data[7:0]);
            CMD_READ_WORD: want.read_data = {fetch_byte(even_addr), fetch_byte(even_addr + 1)};
            CMD_WRITE_WORD: begin
                store_byte(even_addr, data[15:8]);
                store_byte(even_addr + 1, data[7:0]);
            end
            CMD_CONTROL: begin
                if (addr[7:0] == CTRL_LOW_BYTE && span_cfg != 0 && bank_cfg) begin
                    protect_on = data[1];
                    live_on = data[0];
                end
            end
            default: ;
        endcase
        want.save_dirty = dirty_on;
        want.window_live = live_on;
        want.write_protected = protect_on;
        expected_bus_results.push_back(want);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task check_result(logic [23:0] beat);
        bus_result_t got;
        bus_result_t want;
        got = beat[18:0];
        if (expected_bus_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", beat, 0);
            return;
        end
        want = expected_bus_results.pop_front();
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
        if (got.save_dirty !== want.save_dirty)
            report_mismatch("save_dirty", got.save_dirty, want.save_dirty);
        if (got.window_live !== want.window_live)
            report_mismatch("window_live", got.window_live, want.window_live);
        if (got.write_protected !== want.write_protected)
            report_mismatch("write_protected", got.write_protected, want.write_protected);
    endtask
endclass

module tb;

    // Codes the package leaves unnamed: commands the block ignores and register
    // indexes past the end of the list.
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
    localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REG_LAST_UNUSED  = 3'd7;

    // The watchdog must allow the whole reset sweep, which moves nothing on any
    // channel, before it calls the run hung.
    localparam int unsigned WATCHDOG_LIMIT  = 100000;
    localparam int unsigned LONG_HOLD       = 200;
    localparam int unsigned DRAIN_SLACK     = 8;
    localparam int unsigned RANDOM_PHASES   = 10;
    localparam int unsigned ITEMS_PER_PHASE = 172;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] cmd, [26:3] bus_address, [42:27] write_data, [47:43] zero
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] read_data, [16] save_dirty, [17] window_live,
    // [18] write_protected, [23:19] zero
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [21:0] cfg_data = '0;

    save_ram_checker ram_check;

    // Window as the stimulus sees it, used to aim addresses at its edges.
    int unsigned win_base = 0;
    int unsigned win_span = 0;
    bit          win_bank = 1'b0;

    // Remaining items in the sender's current burst.
    int unsigned burst_left = 0;
    // Raised by the stimulus to make the receiver hold off for a long stretch.
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    cart_save_ram_bus_mapper uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every result is checked against the oldest outstanding prediction as it
    // is taken at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            ram_check.check_result(m_tdata);
        end
    end

    // The watchdog only counts cycles in which no channel moves anything, so
    // long runs are fine as long as they keep making progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
                (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver stalls on a rotating bit pattern that is redrawn now and
    // then; a quarter of the patterns never stall. On request it holds off for
    // a long counted stretch so the pipeline backs up into s_tready.
    initial begin : result_sink
        logic [31:0] stall_bits;
        int unsigned run_left;
        stall_bits = '1;
        run_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (run_left == 0) begin
                stall_bits = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
                run_left = $urandom_range(8, 64);
            end
            m_tready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[31:1]};
            run_left--;
        end
    end

    // Offers one access and returns at the falling edge after it is taken.
    // Items within a burst go back to back; between bursts the sender rests
    // for a random gap, and some bursts follow the previous one with no gap.
    task automatic send_access(logic [2:0] cmd, logic [23:0] addr, logic [15:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tdata <= {5'd0, data, addr, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        ram_check.note_access(cmd, addr, data);
        burst_left--;
        @(negedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write so
    // that back-to-back writes never toggle it within one time step.
    task automatic post_register(logic [2:0] idx, logic [21:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        ram_check.apply_register(idx, value);
        @(negedge aclk);
    endtask

    // Writes every register, plus one index past the list that must be
    // ignored. Spare data bits of the one-bit registers carry random noise.
    task automatic apply_settings(logic [21:0] base, logic [21:0] span_word,
                                  bit lane, bit odd, bit bank);
        post_register(REG_WINDOW_BASE, base);
        post_register(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), 22'($urandom));
        post_register(REG_WINDOW_SPAN, span_word);
        post_register(REG_LANE_PACKED, {21'($urandom), lane});
        post_register(REG_ODD_LANE, {21'($urandom), odd});
        post_register(REG_BANK_SWITCHABLE, {21'($urandom), bank});
        cfg_valid <= 1'b0;
        win_base = {10'd0, base[21:1], 1'b0};
        win_span = (span_word[16:0] > SPAN_MAX) ? SPAN_MAX : span_word[16:0];
        win_bank = bank;
    endtask

    // Stops offering items and waits until every result is back. Every item
    // yields a result, so the slack only covers the pipeline settling.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (ram_check.expected_bus_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_SLACK) @(negedge aclk);
    endtask

    // Most addresses land near the window: around its start, or straddling its
    // top edge. The rest are anywhere on the bus.
    function automatic logic [23:0] pick_address();
        int unsigned off;
        int unsigned reach;
        if ($urandom_range(0, 4) == 0) return 24'($urandom);
        reach = (win_span > 128) ? 128 : win_span;
        if ($urandom_range(0, 3) == 0) off = win_span + $urandom_range(0, 7) - 4;
        else off = $urandom_range(0, reach + 3);
        return 24'(win_base + off - 2);
    endfunction

    function automatic void random_access(output logic [2:0] cmd, output logic [23:0] addr,
                                          output logic [15:0] data);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        data = 16'($urandom);
        addr = pick_address();
        if (roll < 3) begin
            cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        end else if (roll < (win_bank ? 15 : 6)) begin
            // Control writes mostly hit the right low byte and mostly switch
            // the RAM in; protect comes on about a sixth of the time.
            cmd = CMD_CONTROL;
            if ($urandom_range(0, 4) != 0) addr[7:0] = CTRL_LOW_BYTE;
            if ($urandom_range(0, 3) != 0) data[0] = 1'b1;
            if ($urandom_range(0, 2) != 0) data[1] = 1'b0;
        end else begin
            cmd = 3'($urandom_range(CMD_READ_BYTE, CMD_WRITE_WORD));
        end
    endfunction

    initial begin : stimulus
        logic [21:0] base;
        logic [21:0] span_word;
        logic [2:0]  cmd;
        logic [23:0] addr;
        logic [15:0] data;
        int unsigned pick;
        ram_check = new();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings have no window: the write is lost and reads return the erased value.
        send_access(CMD_WRITE_BYTE, 24'h200000, 16'h00AB);
        send_access(CMD_READ_WORD, 24'h200000, 16'h0000);
        settle();

        // Word-wide 64-byte window: byte and word round trips, a misaligned
        // word, the last word inside, and the bytes just outside either end.
        apply_settings(BASE_RESET, 22'd64, 1'b0, 1'b0, 1'b0);
        send_access(CMD_WRITE_BYTE, 24'h200000, 16'h77A5);
        send_access(CMD_READ_BYTE, 24'h200000, 16'hFFFF);
        send_access(CMD_READ_BYTE, 24'h200001, 16'h0000);
        send_access(CMD_WRITE_WORD, 24'h200003, 16'h1234);
        send_access(CMD_READ_WORD, 24'h200002, 16'h0000);
        send_access(CMD_READ_BYTE, 24'h200003, 16'h0000);
        send_access(CMD_WRITE_WORD, 24'h20003E, 16'hBEEF);
        send_access(CMD_READ_WORD, 24'h200040, 16'h0000);
        send_access(CMD_READ_WORD, 24'h20003F, 16'h0000);
        send_access(CMD_WRITE_BYTE, 24'h1FFFFF, 16'h0055);
        send_access(CMD_READ_BYTE, 24'h1FFFFF, 16'h0000);
        send_access(CMD_CONTROL, 24'h2000F1, 16'h0003);
        send_access(CMD_FIRST_UNUSED, 24'h200000, 16'hFFFF);
        send_access(CMD_LAST_UNUSED, 24'hFFFFFF, 16'hFFFF);
        settle();

        // Odd base, oversized span, packed on the odd lane, bankable: the RAM
        // starts switched out until a control write at the right low byte.
        apply_settings(22'h3FFFFF, 22'h3FFFFF, 1'b1, 1'b1, 1'b1);
        send_access(CMD_READ_BYTE, 24'h3FFFFF, 16'h0000);
        send_access(CMD_CONTROL, 24'h1234F0, 16'h0001);
        send_access(CMD_CONTROL, 24'h1234F1, 16'h0001);
        send_access(CMD_WRITE_WORD, 24'h3FFFFE, 16'h9966);
        send_access(CMD_READ_WORD, 24'h3FFFFE, 16'h0000);
        send_access(CMD_CONTROL, 24'hFFFFF1, 16'h0003);
        send_access(CMD_WRITE_BYTE, 24'h3FFFFF, 16'h0011);
        send_access(CMD_READ_BYTE, 24'h3FFFFF, 16'h0000);
        send_access(CMD_READ_WORD, 24'hFFFFFF, 16'h0000);
        settle();

        // A three-byte window splits a word at its top edge.
        apply_settings(BASE_RESET, 22'd3, 1'b0, 1'b0, 1'b0);
        send_access(CMD_WRITE_WORD, 24'h200002, 16'hCAFE);
        send_access(CMD_READ_WORD, 24'h200002, 16'h0000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            if (phase == 0) begin
                base = BASE_RESET;
                span_word = {5'd0, SPAN_MAX};
            end else if (phase == 1) begin
                base = 22'h3FFFFE;
                span_word = 22'h01FFFF;
            end else begin
                // Bases mostly inside the documented range, with its ends and
                // some arbitrary ones; spans mostly small so data gets reread.
                pick = $urandom_range(0, 9);
                if (pick < 5) base = 22'($urandom_range(32'h200000, 32'h3FFFFE));
                else if (pick == 5) base = BASE_RESET;
                else if (pick == 6) base = 22'h3FFFFE;
                else base = 22'($urandom);
                pick = $urandom_range(0, 19);
                if (pick < 10) span_word = 22'($urandom_range(1, 64));
                else if (pick < 13) span_word = '0;
                else if (pick < 16) span_word = {5'($urandom), SPAN_MAX};
                else if (pick < 18) span_word = 22'($urandom_range(65, 65535));
                else span_word = 22'($urandom_range(32'h10001, 32'h3FFFFF));
            end
            apply_settings(base, span_word, 1'($urandom), 1'($urandom),
                           (phase == 1) ? 1'b1 : (phase == 0) ? 1'b0 : 1'($urandom));
            if (phase % 4 == 2) hold_request = 1'b1;
            // A bankable cart needs switching in before anything reaches RAM.
            if (win_bank) send_access(CMD_CONTROL, {16'($urandom), CTRL_LOW_BYTE}, 16'h0001);
            repeat (ITEMS_PER_PHASE) begin
                random_access(cmd, addr, data);
                send_access(cmd, addr, data);
            end
        end
        settle();

        if (ram_check.mismatches == 0 && ram_check.expected_bus_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/csrm_pkg.sv
sv/csrm_locate.sv
sv/csrm_store.sv
sv/cart_save_ram_bus_mapper.sv
bench/tb.sv
